// ----- sv/sob_pkg.sv -----
// sob_pkg: shared codes and the result beat type of the stack/queue buffer
// no dependencies
package sob_pkg;

  localparam int unsigned WORD_W = 32;

  // operation codes on the input channel
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_DUMP = 2'd2;

  // status codes on the result channel
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // order_mode values
  localparam logic MODE_STACK = 1'b0;
  localparam logic MODE_QUEUE = 1'b1;

  // register index (word address bit 2 of paddr)
  localparam logic REG_ORDER_MODE = 1'b0;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic [1:0]               status;
    logic                     last;
  } result_t;

endpackage

// ----- sv/sob_ram.sv -----
// sob_ram: word store of the buffer, one write and one registered read port
// depends on sob_pkg for the word width
module sob_ram #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(DEPTH)-1:0]          waddr_i,
  input  logic [sob_pkg::WORD_W-1:0]        wdata_i,
  input  logic                              re_i,
  input  logic [$clog2(DEPTH)-1:0]          raddr_i,
  output logic [sob_pkg::WORD_W-1:0]        rdata_o
);

  logic [sob_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [sob_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/sob_seq.sv -----
// sob_seq: sequencer of the buffer: pointers, occupancy, memory requests, result register
// depends on sob_pkg; drives the ports of sob_ram
module sob_seq #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              order_mode_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        operation_i,
  input  logic [sob_pkg::WORD_W-1:0]        push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sob_pkg::result_t                  out_beat_o,
  output logic                              mem_we_o,
  output logic [$clog2(DEPTH)-1:0]          mem_waddr_o,
  output logic [sob_pkg::WORD_W-1:0]        mem_wdata_o,
  output logic                              mem_re_o,
  output logic [$clog2(DEPTH)-1:0]          mem_raddr_o,
  input  logic [sob_pkg::WORD_W-1:0]        mem_rdata_i
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW:0]   DEPTH_EXT = (PW + 1)'(DEPTH);
  localparam logic [CW-1:0] OCC_FULL  = CW'(DEPTH);
  localparam logic [PW-1:0] SLOT_MAX  = PW'(DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CW-1:0]    occ_q, occ_d;
  logic [PW-1:0]    front_q, front_d;
  logic [PW-1:0]    cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  sob_pkg::result_t out_q, out_d;
  logic             out_load;

  logic             out_free;
  logic             accept;
  logic             empty;
  logic             full;
  logic [PW-1:0]    occ_m1;
  logic [PW-1:0]    rd_idx;
  logic [PW-1:0]    rd_logical;
  logic             dump_last;

  // front + logical stays below twice the depth
  function automatic logic [PW-1:0] wrap_slot(input logic [PW:0] sum);
    logic [PW:0] red;
    red = (sum >= DEPTH_EXT) ? sum - DEPTH_EXT : sum;
    return red[PW-1:0];
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign empty      = (occ_q == '0);
  assign full       = (occ_q == OCC_FULL);
  assign occ_m1     = PW'(occ_q - CW'(1));
  assign dump_last  = (cnt_q == occ_m1);

  // pop and the first dump read share index 0; later dump reads take cnt + 1
  assign rd_idx      = (state_q == S_DUMP) ? cnt_q + PW'(1) : '0;
  assign rd_logical  = (order_mode_i == sob_pkg::MODE_QUEUE) ? rd_idx : occ_m1 - rd_idx;
  assign mem_raddr_o = wrap_slot({1'b0, front_q} + {1'b0, rd_logical});
  assign mem_waddr_o = wrap_slot({1'b0, front_q} + {1'b0, PW'(occ_q)});
  assign mem_wdata_o = push_value_i;

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    front_d     = front_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    out_load    = 1'b0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (operation_i)
            sob_pkg::OP_PUSH: begin
              out_load     = 1'b1;
              out_d.word   = '0;
              out_d.last   = 1'b1;
              if (full) begin
                out_d.status = sob_pkg::STAT_FULL;
              end else begin
                out_d.status = sob_pkg::STAT_OK;
                mem_we_o     = 1'b1;
                occ_d        = occ_q + CW'(1);
              end
            end
            sob_pkg::OP_POP: begin
              if (empty) begin
                out_load     = 1'b1;
                out_d.word   = '0;
                out_d.status = sob_pkg::STAT_EMPTY;
                out_d.last   = 1'b1;
              end else begin
                mem_re_o = 1'b1;
                occ_d    = occ_q - CW'(1);
                if (order_mode_i == sob_pkg::MODE_QUEUE) begin
                  front_d = (front_q == SLOT_MAX) ? '0 : front_q + PW'(1);
                end
                state_d = S_POP;
              end
            end
            sob_pkg::OP_DUMP: begin
              if (!empty) begin
                mem_re_o = 1'b1;
                cnt_d    = '0;
                state_d  = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_d.word   = mem_rdata_i;
          out_d.status = sob_pkg::STAT_OK;
          out_d.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DUMP: begin
        // next read goes out only as the pending word moves to the result register
        if (out_free) begin
          out_load     = 1'b1;
          out_d.word   = mem_rdata_i;
          out_d.status = sob_pkg::STAT_OK;
          out_d.last   = dump_last;
          if (dump_last) begin
            state_d = S_IDLE;
          end else begin
            mem_re_o = 1'b1;
            cnt_d    = cnt_q + PW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      front_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      front_q     <= front_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

// ----- sv/stack_or_queue_buffer.sv -----
// stack_or_queue_buffer: bounded lifo/fifo word buffer with an apb mode register
// depends on sob_pkg, sob_ram and sob_seq
//
//  port group   dir   beat / access
//  in_*         in    operation_i, push_value_i (valid/ready)
//  out_*        out   word_o, status_o, last_o (valid/ready)
//  apb          in    order_mode at byte address 0
//
// push, full push and empty pop: back to back while out_ready_i is high
// pop: the word memory read is registered, so the sequencer waits in S_POP for the word
// dump of n words: the first read goes out as the dump is taken, then one word per cycle while out_ready_i is high
// reset clears occupancy, front pointer and mode; the word memory is not cleared
// a stalled result holds the sequencer; a new beat is taken as the result is taken
module stack_or_queue_buffer #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  operation_i,
  input  logic signed [31:0]          push_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          word_o,
  output logic [1:0]                  status_o,
  output logic                        last_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic                        mode_q, mode_d;
  logic                        cfg_write;
  sob_pkg::result_t            out_beat;
  logic                        mem_we;
  logic [PW-1:0]               mem_waddr;
  logic [sob_pkg::WORD_W-1:0]  mem_wdata;
  logic                        mem_re;
  logic [PW-1:0]               mem_raddr;
  logic [sob_pkg::WORD_W-1:0]  mem_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign mode_d    = (cfg_write && paddr[2] == sob_pkg::REG_ORDER_MODE) ? pwdata[0] : mode_q;
  assign prdata    = (paddr[2] == sob_pkg::REG_ORDER_MODE) ? {31'b0, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sob_pkg::MODE_STACK;
    end else begin
      mode_q <= mode_d;
    end
  end

  sob_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sob_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .order_mode_i (mode_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_beat_o   (out_beat),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  assign word_o   = out_beat.word;
  assign status_o = out_beat.status;
  assign last_o   = out_beat.last;

  // error results are always single beats
  a_err_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != sob_pkg::STAT_OK |-> last_o)
    else $error("error status on a non-final result beat");

  // error results carry a zero word
  a_err_word_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != sob_pkg::STAT_OK |-> word_o == '0)
    else $error("error result with nonzero word");

  // a mode write lands in the register
  a_mode_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_write && paddr[2] == sob_pkg::REG_ORDER_MODE |=> mode_q == $past(pwdata[0]))
    else $error("order mode write lost");

endmodule
